/* hw/rtl/bpu_pkg.sv */
// Shared types, codes and constants of the BMP pixel unpack unit.
package bpu_pkg;

  // Field and register widths fixed by the interface
  localparam int COLOR_W    = 32;
  localparam int COORD_W    = 13;
  localparam int YOFF_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Depth of the queue between the byte front end and the write generator
  localparam int QUEUE_DEPTH = 2;

  // Row counter saturates here
  localparam logic [COORD_W-1:0] ROW_LIMIT = 13'h1FFF;

  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_PIXEL   = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    FMT_4BPP  = 2'd0,
    FMT_8BPP  = 2'd1,
    FMT_24BPP = 2'd2,
    FMT_32BPP = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    KEY_ALL   = 2'd0,
    KEY_SKIP  = 2'd1,
    KEY_SUBST = 2'd2
  } key_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_FORMAT = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_ORIGIN_X     = 3'd2,
    REG_BOTTOM_Y     = 3'd3,
    REG_ZOOM_FACTOR  = 3'd4,
    REG_KEY_MODE     = 3'd5,
    REG_KEY_COLOR    = 3'd6,
    REG_SUBST_COLOR  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE  = 2'd0,
    F_READ0 = 2'd1,
    F_READ1 = 2'd2
  } front_state_e;

  // Configuration as seen by the datapath: width and zoom already clamped
  typedef struct packed {
    fmt_e                 pixel_format;
    logic [10:0]          image_width;
    logic [9:0]           origin_x;
    logic [COORD_W-1:0]   bottom_y;
    logic [2:0]           zoom;
    logic [1:0]           key_mode;
    logic [COLOR_W-1:0]   key_color;
    logic [COLOR_W-1:0]   substitute_color;
  } cfg_t;

  // One decoded pixel: color, left x of its block, row offset times zoom
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] xbase;
    logic [YOFF_W-1:0]  yoff;
  } pix_t;

  // Everything one data byte produces
  typedef struct packed {
    pix_t pix0;
    pix_t pix1;
    logic two_pixels;
  } entry_t;

endpackage

/* hw/rtl/bpu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bpu_front.sv */
// Front end: takes beats, keeps the palette, unpacks bytes into positioned pixels.
module bpu_front #(
  parameter int MAX_WIDTH     = 1024,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bpu_pkg::cfg_t                   cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  logic                            first_byte_i,
  input  logic [7:0]                      palette_slot_i,
  input  logic [bpu_pkg::COLOR_W-1:0]     palette_word_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output bpu_pkg::entry_t                 q_data_o
);

  localparam int IW    = $clog2(PALETTE_DEPTH);
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SLOTS = 256;

  // Slot and index wrap, built at elaboration
  function automatic logic [SLOTS*IW-1:0] build_wrap();
    logic [SLOTS*IW-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl[i*IW +: IW] = IW'(i % PALETTE_DEPTH);
    end
    return tbl;
  endfunction

  localparam logic [SLOTS*IW-1:0] WRAP_TBL = build_wrap();

  // Screen placement of the pixel at column col, row row
  function automatic bpu_pkg::pix_t place(input logic [CW-1:0] col,
                                          input logic [12:0]   row,
                                          input bpu_pkg::cfg_t cfg);
    bpu_pkg::pix_t p;
    logic [15:0]   cz;
    cz      = 16'(col) * 16'(cfg.zoom);
    p.color = '0;
    p.xbase = 13'(16'(cfg.origin_x) + cz);
    p.yoff  = 15'(16'(row) * 16'(cfg.zoom));
    return p;
  endfunction

  // Step to the next pixel position, wrapping at the row end
  function automatic logic [CW+12:0] advance(input logic [CW-1:0] col,
                                             input logic [12:0]   row,
                                             input logic [10:0]   width);
    logic [12:0] nxt;
    logic [12:0] r;
    nxt = 13'(col) + 13'd1;
    r   = row;
    if (nxt >= 13'(width)) begin
      nxt = '0;
      if (row != bpu_pkg::ROW_LIMIT) begin
        r = row + 13'd1;
      end
    end
    return {CW'(nxt), r};
  endfunction

  bpu_pkg::front_state_e state_q, state_d;
  logic [CW-1:0]         col_q, col_d, col_b;
  logic [12:0]           row_q, row_d, row_b;
  logic [1:0]            phase_q, phase_d, phase_b;
  logic [15:0]           part_q, part_d, part_b;
  logic [3:0]            nib_q, nib_d;
  bpu_pkg::entry_t       entry_q, entry_d;
  logic [CW+12:0]        pos1, pos2;
  logic                  accept;
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [IW-1:0]         ram_raddr;
  logic [bpu_pkg::COLOR_W-1:0] ram_rdata;

  bpu_ram #(
    .WIDTH (bpu_pkg::COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (palette_word_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Accept only when idle and the queue has room for this byte's entry
  assign in_stall_o = (state_q != bpu_pkg::F_IDLE) || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign ram_waddr  = WRAP_TBL[int'(palette_slot_i)*IW +: IW];

  // Counters as they stand for this byte, cleared on an image's first byte
  assign col_b   = first_byte_i ? '0 : col_q;
  assign row_b   = first_byte_i ? '0 : row_q;
  assign phase_b = first_byte_i ? '0 : phase_q;
  assign part_b  = first_byte_i ? '0 : part_q;
  assign pos1    = advance(col_b, row_b, cfg_i.image_width);
  assign pos2    = advance(pos1[CW+12:13], pos1[12:0], cfg_i.image_width);

  // State and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpu_pkg::F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
      part_q  <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
      part_q  <= part_d;
    end
  end

  // Entry under construction
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    nib_q   <= nib_d;
  end

  // Decode bytes, sequence palette reads, push finished entries
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    phase_d   = phase_q;
    part_d    = part_q;
    nib_d     = nib_q;
    entry_d   = entry_q;
    q_push_o  = 1'b0;
    q_data_o  = entry_q;
    ram_we    = 1'b0;
    ram_raddr = IW'(nib_q);
    case (state_q)
      bpu_pkg::F_IDLE: begin
        if (accept && opcode_i == bpu_pkg::OP_PALETTE) begin
          ram_we = 1'b1;
        end else if (accept) begin
          col_d   = col_b;
          row_d   = row_b;
          phase_d = phase_b;
          part_d  = part_b;
          case (cfg_i.pixel_format)
            bpu_pkg::FMT_4BPP: begin
              entry_d.pix0       = place(col_b, row_b, cfg_i);
              entry_d.pix1       = place(pos1[CW+12:13], pos1[12:0], cfg_i);
              entry_d.two_pixels = 1'b1;
              {col_d, row_d}     = pos2;
              phase_d            = '0;
              part_d             = '0;
              ram_raddr          = IW'(data_byte_i[7:4]);
              nib_d              = data_byte_i[3:0];
              state_d            = bpu_pkg::F_READ0;
            end
            bpu_pkg::FMT_8BPP: begin
              entry_d.pix0       = place(col_b, row_b, cfg_i);
              entry_d.pix1       = '0;
              entry_d.two_pixels = 1'b0;
              {col_d, row_d}     = pos1;
              phase_d            = '0;
              part_d             = '0;
              ram_raddr          = WRAP_TBL[int'(data_byte_i)*IW +: IW];
              state_d            = bpu_pkg::F_READ0;
            end
            default: begin
              // Gather B, G, then emit on R; drop the 32bpp pad byte
              if (phase_b == 2'd0) begin
                part_d  = {8'h00, data_byte_i};
                phase_d = 2'd1;
              end else if (phase_b == 2'd1) begin
                part_d  = {data_byte_i, part_b[7:0]};
                phase_d = 2'd2;
              end else if (phase_b == 2'd2 || cfg_i.pixel_format == bpu_pkg::FMT_24BPP) begin
                q_data_o.pix0       = place(col_b, row_b, cfg_i);
                q_data_o.pix0.color = {8'h00, data_byte_i, part_b};
                q_data_o.pix1       = '0;
                q_data_o.two_pixels = 1'b0;
                q_push_o            = 1'b1;
                {col_d, row_d}      = pos1;
                part_d              = '0;
                phase_d = (cfg_i.pixel_format == bpu_pkg::FMT_32BPP) ? 2'd3 : 2'd0;
              end else begin
                phase_d = 2'd0;
              end
            end
          endcase
        end
      end
      bpu_pkg::F_READ0: begin
        // First palette color lands; fetch the low nibble's color if any
        entry_d.pix0.color  = ram_rdata;
        q_data_o.pix0.color = ram_rdata;
        if (entry_q.two_pixels) begin
          state_d = bpu_pkg::F_READ1;
        end else begin
          q_push_o = 1'b1;
          state_d  = bpu_pkg::F_IDLE;
        end
      end
      bpu_pkg::F_READ1: begin
        q_data_o.pix1.color = ram_rdata;
        q_push_o            = 1'b1;
        state_d             = bpu_pkg::F_IDLE;
      end
      default: begin
        state_d = bpu_pkg::F_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/bpu_queue.sv */
// Small entry queue between the byte front end and the write generator.
module bpu_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bpu_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output bpu_pkg::entry_t head_o,
  output logic            empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  bpu_pkg::entry_t mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [NW-1:0]   cnt_q;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(DEPTH));

endmodule

/* hw/rtl/bpu_back.sv */
// Back end: applies the color key and expands each pixel into zoomed writes.
module bpu_back #(
  parameter int MAX_ZOOM = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bpu_pkg::cfg_t               cfg_i,
  input  bpu_pkg::entry_t             head_i,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bpu_pkg::COORD_W-1:0] pixel_x_o,
  output logic [bpu_pkg::COORD_W-1:0] pixel_y_o,
  output logic [bpu_pkg::COLOR_W-1:0] pixel_color_o,
  output logic                        run_last_o
);

  localparam int ZW = (MAX_ZOOM > 1) ? $clog2(MAX_ZOOM) : 1;

  // A pixel yields writes unless keyed out or wholly above the screen top
  function automatic logic visible(input bpu_pkg::pix_t p, input bpu_pkg::cfg_t c);
    logic match;
    match = (p.color == c.key_color);
    return !(c.key_mode == bpu_pkg::KEY_SKIP && match) &&
           (bpu_pkg::YOFF_W'(c.bottom_y) >= p.yoff);
  endfunction

  logic                        p_q, p_d;
  logic [ZW-1:0]               dx_q, dx_d, dy_q, dy_d;
  logic                        out_valid_q, out_valid_d;
  logic [bpu_pkg::COORD_W-1:0] x_q, y_q;
  logic [bpu_pkg::COLOR_W-1:0] color_q, color_cur;
  logic                        last_q, last_cur;
  bpu_pkg::pix_t               cur;
  logic                        vis0, vis1, vis_cur;
  logic [bpu_pkg::YOFF_W-1:0]  ysum;
  logic                        dx_end, dy_end, out_free, load, pix_done;

  assign cur      = p_q ? head_i.pix1 : head_i.pix0;
  assign vis0     = visible(head_i.pix0, cfg_i);
  assign vis1     = visible(head_i.pix1, cfg_i);
  assign vis_cur  = p_q ? vis1 : vis0;
  assign ysum     = cur.yoff + bpu_pkg::YOFF_W'(dy_q);
  assign dx_end   = (3'(dx_q) + 3'd1 == cfg_i.zoom);
  assign dy_end   = (3'(dy_q) + 3'd1 == cfg_i.zoom) ||
                    (ysum == bpu_pkg::YOFF_W'(cfg_i.bottom_y));
  assign out_free = !out_valid_q || !out_stall_i;

  // Substitute the key color when asked
  assign color_cur = (cfg_i.key_mode == bpu_pkg::KEY_SUBST && cur.color == cfg_i.key_color)
                     ? cfg_i.substitute_color : cur.color;

  // Last write of the byte: end of this pixel, and no later pixel draws
  assign last_cur = dx_end && dy_end && (p_q || !head_i.two_pixels || !vis1);

  // Walk dx inside dy inside the pixels of the head entry
  always_comb begin
    p_d      = p_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    load     = 1'b0;
    pix_done = 1'b0;
    q_pop_o  = 1'b0;
    if (!q_empty_i && out_free) begin
      if (vis_cur) begin
        load = 1'b1;
        if (dx_end) begin
          dx_d = '0;
          if (dy_end) begin
            dy_d     = '0;
            pix_done = 1'b1;
          end else begin
            dy_d = dy_q + ZW'(1);
          end
        end else begin
          dx_d = dx_q + ZW'(1);
        end
      end else begin
        pix_done = 1'b1;
      end
      if (pix_done) begin
        if (head_i.two_pixels && !p_q) begin
          p_d = 1'b1;
        end else begin
          p_d     = 1'b0;
          q_pop_o = 1'b1;
        end
      end
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q         <= 1'b0;
      dx_q        <= '0;
      dy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      p_q         <= p_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output beat register
  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q     <= cur.xbase + bpu_pkg::COORD_W'(dx_q);
      y_q     <= bpu_pkg::COORD_W'(bpu_pkg::YOFF_W'(cfg_i.bottom_y) - ysum);
      color_q <= color_cur;
      last_q  <= last_cur;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = x_q;
  assign pixel_y_o     = y_q;
  assign pixel_color_o = color_q;
  assign run_last_o    = last_q;

endmodule

/* hw/rtl/bmp_pixel_unpack_colorkey_zoom_unit.sv */
// BMP pixel unpacker with color key and zoom, top level.
//
// Feed palette writes and pixel-data bytes on the input channel; each visible
// pixel comes out as zoom x zoom framebuffer writes, rows drawn bottom-up from
// bottom_y, run_last set on the final write of each byte. A palette write or a
// 24/32bpp byte is taken without leaving idle; an 8bpp byte passes F_READ0 and
// a 4bpp byte F_READ0 and F_READ1, set by the palette RAM's single registered
// read port (one lookup per nibble). The write generator gives one write per
// cycle unless the output stalls, z*z per drawn pixel fewer any rows above the
// screen top; a keyed-out or fully hidden pixel is stepped past with no write.
// A two-entry queue lets front and back stall independently.
// Write configuration only while the unit is idle. No clearing pass after reset.
module bmp_pixel_unpack_colorkey_zoom_unit #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_ZOOM      = 4,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bpu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic                           first_byte_i,
  input  logic [7:0]                     palette_slot_i,
  input  logic [31:0]                    palette_word_i,
  input  logic [7:0]                     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [12:0]                    pixel_x_o,
  output logic [12:0]                    pixel_y_o,
  output logic [31:0]                    pixel_color_o,
  output logic                           run_last_o
);

  bpu_pkg::fmt_e   fmt_q;
  logic [10:0]     width_q;
  logic [9:0]      origin_q;
  logic [12:0]     bottom_q;
  logic [2:0]      zoom_q;
  logic [1:0]      key_mode_q;
  logic [31:0]     key_color_q;
  logic [31:0]     subst_color_q;
  bpu_pkg::cfg_t   cfg;
  bpu_pkg::entry_t q_push_data, q_head;
  logic            q_push, q_pop, q_full, q_empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q         <= bpu_pkg::FMT_8BPP;
      width_q       <= 11'd1;
      origin_q      <= '0;
      bottom_q      <= '0;
      zoom_q        <= 3'd1;
      key_mode_q    <= bpu_pkg::KEY_ALL;
      key_color_q   <= '0;
      subst_color_q <= '0;
    end else if (cfg_we_i) begin
      case (bpu_pkg::reg_idx_e'(cfg_index_i))
        bpu_pkg::REG_PIXEL_FORMAT: fmt_q         <= bpu_pkg::fmt_e'(cfg_data_i[1:0]);
        bpu_pkg::REG_IMAGE_WIDTH:  width_q       <= cfg_data_i[10:0];
        bpu_pkg::REG_ORIGIN_X:     origin_q      <= cfg_data_i[9:0];
        bpu_pkg::REG_BOTTOM_Y:     bottom_q      <= cfg_data_i[12:0];
        bpu_pkg::REG_ZOOM_FACTOR:  zoom_q        <= cfg_data_i[2:0];
        bpu_pkg::REG_KEY_MODE:     key_mode_q    <= cfg_data_i[1:0];
        bpu_pkg::REG_KEY_COLOR:    key_color_q   <= cfg_data_i;
        bpu_pkg::REG_SUBST_COLOR:  subst_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp width and zoom into their supported ranges
  always_comb begin
    cfg.pixel_format     = fmt_q;
    cfg.origin_x         = origin_q;
    cfg.bottom_y         = bottom_q;
    cfg.key_mode         = key_mode_q;
    cfg.key_color        = key_color_q;
    cfg.substitute_color = subst_color_q;
    if (width_q == '0) begin
      cfg.image_width = 11'd1;
    end else if (13'(width_q) > 13'(MAX_WIDTH)) begin
      cfg.image_width = 11'(MAX_WIDTH);
    end else begin
      cfg.image_width = width_q;
    end
    if (zoom_q == '0) begin
      cfg.zoom = 3'd1;
    end else if (zoom_q > 3'(MAX_ZOOM)) begin
      cfg.zoom = 3'(MAX_ZOOM);
    end else begin
      cfg.zoom = zoom_q;
    end
  end

  bpu_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .first_byte_i   (first_byte_i),
    .palette_slot_i (palette_slot_i),
    .palette_word_i (palette_word_i),
    .data_byte_i    (data_byte_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_push_data)
  );

  bpu_queue #(
    .DEPTH (bpu_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  bpu_back #(
    .MAX_ZOOM (MAX_ZOOM)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .head_i        (q_head),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .run_last_o    (run_last_o)
  );

endmodule

/* hw/rtl/bpu_checker.sv */
// Port-level assertions for the BMP pixel unpack unit, bound to the top level.
module bpu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        opcode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [12:0] pixel_x_o,
  input logic [12:0] pixel_y_o,
  input logic [31:0] pixel_color_o,
  input logic        run_last_o
);

  logic seen_pixel_q;

  // Remember whether any pixel-data beat has gone in since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_pixel_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o && opcode_i == bpu_pkg::OP_PIXEL) begin
      seen_pixel_q <= 1'b1;
    end
  end

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_x_o) &&
      $stable(pixel_y_o) && $stable(pixel_color_o) && $stable(run_last_o))
    else $error("stalled output beat changed");

  // No write appears before any pixel byte was taken
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_pixel_q)
    else $error("output beat with no pixel byte accepted");

  // A palette write never leaves the front end busy
  a_palette_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i == bpu_pkg::OP_PALETTE |=> !in_stall_o)
    else $error("input stalled right after a palette write");

endmodule

bind bmp_pixel_unpack_colorkey_zoom_unit bpu_checker u_bpu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .opcode_i      (opcode_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pixel_x_o     (pixel_x_o),
  .pixel_y_o     (pixel_y_o),
  .pixel_color_o (pixel_color_o),
  .run_last_o    (run_last_o)
);
